@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

   // Push-back stack for the input byte and re-fed lookahead bytes
   localparam int STK_DEPTH = 8;
   localparam int STK_IDX_W = $clog2(STK_DEPTH);
   localparam int STK_CNT_W = $clog2(STK_DEPTH + 1);

   // Buffer for hex digits and surrogate lookahead bytes
   localparam int PEND_DEPTH = 7;
   localparam int PEND_IDX_W = $clog2(PEND_DEPTH);

   // Escape lengths after the backslash-u
   localparam int HEX_DIGITS = 4;
   localparam int LOOK_LEN   = 6;

   // Most output bytes per input item; the rest are dropped
   localparam int MAX_OUT   = 8;
   localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

   // Characters
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_QMARK     = 8'h3F;
   localparam logic [7:0] CH_0         = 8'h30;
   localparam logic [7:0] CH_9         = 8'h39;
   localparam logic [7:0] CH_LOW_A     = 8'h61;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_UP_A      = 8'h41;
   localparam logic [7:0] CH_UP_F      = 8'h46;

   // Control codes produced by the simple escapes
   localparam logic [7:0] CODE_BS  = 8'h08;
   localparam logic [7:0] CODE_FF  = 8'h0C;
   localparam logic [7:0] CODE_LF  = 8'h0A;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_TAB = 8'h09;

   // Code point limits
   localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
   localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
   localparam logic [20:0] CP_SUPP_BASE  = 21'h10000;
   localparam logic [20:0] CP_REPLACE    = 21'h0FFFD;
   localparam logic [20:0] UTF8_MAX1     = 21'h0007F;
   localparam logic [20:0] UTF8_MAX2     = 21'h007FF;
   localparam logic [20:0] UTF8_MAX3     = 21'h0FFFF;

   // Parser phase
   typedef enum logic [1:0] {
      PH_TEXT,
      PH_ESC,
      PH_HEX,
      PH_LOOK
   } phase_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROC,
      ST_EMIT,
      ST_REPLAY
   } ctl_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic take_in;
      logic proc;
      logic emit;
      logic replay;
      logic end_step;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic proc_block;
      logic emit_block;
      logic dec_more;
      logic dec_rep;
      logic stk_more;
      logic stk_any;
      logic enc_more;
      logic rep_more;
      logic rep_any;
   } dp_status_type;

endpackage

@@ rtl/json_string_unescape_to_utf8_top.sv @@
// JSON string unescaper: takes the escaped body of a string one byte per beat, with
// string_end on its final byte, and returns the unescaped bytes with \uXXXX escapes
// written as UTF-8; run_last marks the last output byte caused by each input beat, and
// a beat may cause no output at all. A byte that passes through or is absorbed is
// accepted and then decoded; the further bytes of a multi-byte UTF-8 code point follow
// from the output stage, one byte per cycle unless the result channel stalls. When a
// surrogate lookahead or a short \u fails, the buffered bytes (up to six) are pushed
// back into the decoder one per cycle and then decoded again; a replayed \u that the
// end cuts short replays its digits once more. Output trails by one byte, held until
// the block knows whether it is the last of its beat, and a stalled result channel
// stalls decoding once that byte and the output register are full.
module json_string_unescape_to_utf8_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  jsu_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output jsu_pkg::rsp_payload_type rsp_payload
);

   jsu_pkg::ctl_cmd_type   cmd;
   jsu_pkg::dp_status_type status;

   // Sequencer
   jsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Decoder, buffers and output stage
   jsu_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/jsu_ctrl.sv @@
module jsu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  jsu_pkg::dp_status_type status,
   output jsu_pkg::ctl_cmd_type   cmd
);

   jsu_pkg::ctl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jsu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jsu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = jsu_pkg::ST_PROC;
            end
         end
         jsu_pkg::ST_PROC: begin
            if (!status.proc_block) begin
               if (status.dec_more) begin
                  state_in = jsu_pkg::ST_EMIT;
               end else if (status.dec_rep) begin
                  state_in = jsu_pkg::ST_REPLAY;
               end else if (status.stk_more) begin
                  state_in = jsu_pkg::ST_PROC;
               end else begin
                  state_in = jsu_pkg::ST_IDLE;
               end
            end
         end
         jsu_pkg::ST_EMIT: begin
            if (!status.emit_block) begin
               if (status.enc_more) begin
                  state_in = jsu_pkg::ST_EMIT;
               end else if (status.rep_any) begin
                  state_in = jsu_pkg::ST_REPLAY;
               end else if (status.stk_any) begin
                  state_in = jsu_pkg::ST_PROC;
               end else begin
                  state_in = jsu_pkg::ST_IDLE;
               end
            end
         end
         jsu_pkg::ST_REPLAY: begin
            if (!status.rep_more) begin
               state_in = jsu_pkg::ST_PROC;
            end
         end
         default: begin
            state_in = jsu_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         jsu_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.take_in = req_valid;
         end
         jsu_pkg::ST_PROC: begin
            cmd.proc     = !status.proc_block;
            cmd.end_step = !status.proc_block && !status.dec_more && !status.dec_rep
                           && !status.stk_more;
         end
         jsu_pkg::ST_EMIT: begin
            cmd.emit     = !status.emit_block;
            cmd.end_step = !status.emit_block && !status.enc_more && !status.rep_any
                           && !status.stk_any;
         end
         jsu_pkg::ST_REPLAY: begin
            cmd.replay = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/jsu_dpath.sv @@
module jsu_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  jsu_pkg::req_payload_type req_payload,
   input  jsu_pkg::ctl_cmd_type     cmd,
   output jsu_pkg::dp_status_type   status,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output jsu_pkg::rsp_payload_type rsp_payload
);

   // Hex digit decode: bit 4 flags a valid digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {[jsu_pkg::CH_0 : jsu_pkg::CH_9]}) begin
         r = {1'b1, 4'(c - jsu_pkg::CH_0)};
      end else if (c inside {[jsu_pkg::CH_LOW_A : jsu_pkg::CH_LOW_F]}) begin
         r = {1'b1, 4'(c - jsu_pkg::CH_LOW_A) + 4'd10};
      end else if (c inside {[jsu_pkg::CH_UP_A : jsu_pkg::CH_UP_F]}) begin
         r = {1'b1, 4'(c - jsu_pkg::CH_UP_A) + 4'd10};
      end
      return r;
   endfunction

   // Push-back stack
   logic [7:0]                      stk_byte_ff [jsu_pkg::STK_DEPTH];
   logic                            stk_end_ff  [jsu_pkg::STK_DEPTH];
   logic [jsu_pkg::STK_CNT_W-1:0]   stk_cnt_ff, stk_cnt_in;
   logic [jsu_pkg::STK_CNT_W-1:0]   top_pos;
   logic                            push_en;
   logic [7:0]                      push_byte;
   logic                            push_end;
   logic [7:0]                      cur_byte;
   logic                            cur_end;

   // Parser state
   jsu_pkg::phase_type              phase_ff, phase_in;
   logic [jsu_pkg::PEND_IDX_W-1:0]  pcnt_ff, pcnt_in;
   logic [7:0]                      pend_ff [jsu_pkg::PEND_DEPTH];
   logic [9:0]                      hi_bits_ff, hi_bits_in;
   logic                            step_end_ff, step_end_in;

   // Encoded bytes still to send, bytes still to push back
   logic [7:0]                      enc_ff [3];
   logic [7:0]                      enc_in [3];
   logic [1:0]                      enc_left_ff, enc_left_in;
   logic [jsu_pkg::PEND_IDX_W-1:0]  rep_left_ff, rep_left_in;
   logic [jsu_pkg::PEND_IDX_W-1:0]  rep_pos;
   logic                            rep_end_ff, rep_end_in;

   // Output staging
   logic [jsu_pkg::OUT_CNT_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic                            hold_vld_ff, hold_vld_in;
   logic [7:0]                      hold_byte_ff, hold_byte_in;
   logic                            hold_last_ff, hold_last_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   jsu_pkg::rsp_payload_type        rsp_data_ff, rsp_data_in;

   // Decision for the byte on top of the stack
   logic [jsu_pkg::PEND_IDX_W-1:0]  pc1;
   logic [7:0]                      hx [4];
   logic [4:0]                      hd [4];
   logic [15:0]                     hex_v;
   logic                            hex_ok;
   logic                            is_high;
   logic                            is_low;
   jsu_pkg::phase_type              dec_phase;
   logic [jsu_pkg::PEND_IDX_W-1:0]  dec_pcnt;
   logic                            dec_wr_pend;
   logic                            dec_hi_wr;
   logic                            dec_raw;
   logic [7:0]                      dec_raw_byte;
   logic                            dec_use_cp;
   logic [20:0]                     dec_cp;
   logic [jsu_pkg::PEND_IDX_W-1:0]  dec_rep_n;
   logic                            dec_rep_e;
   logic [2:0]                      dec_len;
   logic [7:0]                      dec_byte [4];

   logic                            slot_free;
   logic                            emit_ok;
   logic                            cap_ok;
   logic                            em_req;
   logic                            em_do;
   logic [7:0]                      em_byte;
   logic                            hold_move;

   // Stack top and push source
   always_comb begin
      top_pos   = stk_cnt_ff - jsu_pkg::STK_CNT_W'(1);
      cur_byte  = stk_byte_ff[top_pos[jsu_pkg::STK_IDX_W-1:0]];
      cur_end   = stk_end_ff[top_pos[jsu_pkg::STK_IDX_W-1:0]];
      rep_pos   = rep_left_ff - jsu_pkg::PEND_IDX_W'(1);
      push_en   = cmd.take_in || cmd.replay;
      push_byte = cmd.take_in ? req_payload.in_byte : pend_ff[rep_pos];
      push_end  = cmd.take_in ? req_payload.string_end : rep_end_ff;
   end

   // Four hex digits: buffered ones plus the current byte
   always_comb begin
      if (phase_ff == jsu_pkg::PH_LOOK) begin
         hx[0] = pend_ff[2];
         hx[1] = pend_ff[3];
         hx[2] = pend_ff[4];
      end else begin
         hx[0] = pend_ff[0];
         hx[1] = pend_ff[1];
         hx[2] = pend_ff[2];
      end
      hx[3] = cur_byte;
      for (int i = 0; i < 4; i++) begin
         hd[i] = hex_digit(hx[i]);
      end
      hex_v   = {hd[0][3:0], hd[1][3:0], hd[2][3:0], hd[3][3:0]};
      hex_ok  = hd[0][4] && hd[1][4] && hd[2][4] && hd[3][4];
      is_high = hex_v inside {[jsu_pkg::SURR_HIGH_MIN : jsu_pkg::SURR_HIGH_MAX]};
      is_low  = hex_v inside {[jsu_pkg::SURR_LOW_MIN : jsu_pkg::SURR_LOW_MAX]};
   end

   // Byte decision
   always_comb begin
      pc1          = pcnt_ff + jsu_pkg::PEND_IDX_W'(1);
      dec_phase    = phase_ff;
      dec_pcnt     = pcnt_ff;
      dec_wr_pend  = 1'b0;
      dec_hi_wr    = 1'b0;
      dec_raw      = 1'b0;
      dec_raw_byte = cur_byte;
      dec_use_cp   = 1'b0;
      dec_cp       = jsu_pkg::CP_REPLACE;
      dec_rep_n    = '0;
      dec_rep_e    = 1'b0;
      case (phase_ff)
         jsu_pkg::PH_TEXT: begin
            if (cur_byte == jsu_pkg::CH_BACKSLASH) begin
               if (!cur_end) begin
                  dec_phase = jsu_pkg::PH_ESC;
               end
            end else begin
               dec_raw = 1'b1;
            end
         end
         jsu_pkg::PH_ESC: begin
            dec_phase = jsu_pkg::PH_TEXT;
            dec_raw   = 1'b1;
            case (cur_byte)
               jsu_pkg::CH_B: dec_raw_byte = jsu_pkg::CODE_BS;
               jsu_pkg::CH_F: dec_raw_byte = jsu_pkg::CODE_FF;
               jsu_pkg::CH_N: dec_raw_byte = jsu_pkg::CODE_LF;
               jsu_pkg::CH_R: dec_raw_byte = jsu_pkg::CODE_CR;
               jsu_pkg::CH_T: dec_raw_byte = jsu_pkg::CODE_TAB;
               jsu_pkg::CH_U: begin
                  if (cur_end) begin
                     dec_raw_byte = jsu_pkg::CH_QMARK;
                  end else begin
                     dec_raw   = 1'b0;
                     dec_phase = jsu_pkg::PH_HEX;
                     dec_pcnt  = '0;
                  end
               end
               default: dec_raw_byte = cur_byte;
            endcase
         end
         jsu_pkg::PH_HEX: begin
            dec_wr_pend = 1'b1;
            if (pc1 < jsu_pkg::PEND_IDX_W'(jsu_pkg::HEX_DIGITS)) begin
               if (cur_end) begin
                  // cut short by the end: '?' and feed the digits again
                  dec_raw      = 1'b1;
                  dec_raw_byte = jsu_pkg::CH_QMARK;
                  dec_rep_n    = pc1;
                  dec_rep_e    = 1'b1;
                  dec_phase    = jsu_pkg::PH_TEXT;
                  dec_pcnt     = '0;
               end else begin
                  dec_pcnt = pc1;
               end
            end else begin
               dec_pcnt  = '0;
               dec_phase = jsu_pkg::PH_TEXT;
               if (!hex_ok) begin
                  dec_raw      = 1'b1;
                  dec_raw_byte = jsu_pkg::CH_QMARK;
               end else if (is_high) begin
                  dec_hi_wr = 1'b1;
                  if (cur_end) begin
                     dec_use_cp = 1'b1;
                  end else begin
                     dec_phase = jsu_pkg::PH_LOOK;
                  end
               end else if (is_low) begin
                  dec_use_cp = 1'b1;
               end else begin
                  dec_use_cp = 1'b1;
                  dec_cp     = {5'b0, hex_v};
               end
            end
         end
         jsu_pkg::PH_LOOK: begin
            dec_wr_pend = 1'b1;
            if ((pc1 == jsu_pkg::PEND_IDX_W'(1) && cur_byte != jsu_pkg::CH_BACKSLASH) ||
                (pc1 == jsu_pkg::PEND_IDX_W'(2) && cur_byte != jsu_pkg::CH_U)) begin
               // no escape follows the high surrogate
               dec_use_cp = 1'b1;
               dec_rep_n  = pc1;
               dec_rep_e  = cur_end;
               dec_phase  = jsu_pkg::PH_TEXT;
               dec_pcnt   = '0;
            end else if (pc1 < jsu_pkg::PEND_IDX_W'(jsu_pkg::LOOK_LEN)) begin
               if (cur_end) begin
                  dec_use_cp = 1'b1;
                  dec_rep_n  = pc1;
                  dec_rep_e  = 1'b1;
                  dec_phase  = jsu_pkg::PH_TEXT;
                  dec_pcnt   = '0;
               end else begin
                  dec_pcnt = pc1;
               end
            end else begin
               dec_use_cp = 1'b1;
               dec_phase  = jsu_pkg::PH_TEXT;
               dec_pcnt   = '0;
               if (hex_ok && is_low) begin
                  // surrogate pair
                  dec_cp = jsu_pkg::CP_SUPP_BASE + {1'b0, hi_bits_ff, hex_v[9:0]};
               end else begin
                  dec_rep_n = pc1;
                  dec_rep_e = cur_end;
               end
            end
         end
         default: begin
            dec_phase = jsu_pkg::PH_TEXT;
         end
      endcase
   end

   // UTF-8 encode of the decision
   always_comb begin
      dec_len = 3'd0;
      for (int i = 0; i < 4; i++) begin
         dec_byte[i] = '0;
      end
      if (dec_use_cp) begin
         if (dec_cp <= jsu_pkg::UTF8_MAX1) begin
            dec_len     = 3'd1;
            dec_byte[0] = dec_cp[7:0];
         end else if (dec_cp <= jsu_pkg::UTF8_MAX2) begin
            dec_len     = 3'd2;
            dec_byte[0] = {3'b110, dec_cp[10:6]};
            dec_byte[1] = {2'b10, dec_cp[5:0]};
         end else if (dec_cp <= jsu_pkg::UTF8_MAX3) begin
            dec_len     = 3'd3;
            dec_byte[0] = {4'b1110, dec_cp[15:12]};
            dec_byte[1] = {2'b10, dec_cp[11:6]};
            dec_byte[2] = {2'b10, dec_cp[5:0]};
         end else begin
            dec_len     = 3'd4;
            dec_byte[0] = {5'b11110, dec_cp[20:18]};
            dec_byte[1] = {2'b10, dec_cp[17:12]};
            dec_byte[2] = {2'b10, dec_cp[11:6]};
            dec_byte[3] = {2'b10, dec_cp[5:0]};
         end
      end else if (dec_raw) begin
         dec_len     = 3'd1;
         dec_byte[0] = dec_raw_byte;
      end
   end

   // Emission into the one-byte hold stage
   always_comb begin
      slot_free = !rsp_vld_ff || rsp_ready;
      emit_ok   = !hold_vld_ff || slot_free;
      cap_ok    = emit_cnt_ff != jsu_pkg::OUT_CNT_W'(jsu_pkg::MAX_OUT);
      em_req    = (cmd.proc && dec_len != 3'd0) || cmd.emit;
      em_do     = em_req && cap_ok;
      em_byte   = cmd.proc ? dec_byte[0] : enc_ff[0];
      hold_move = hold_vld_ff && slot_free && (hold_last_ff || em_do);
   end

   // Next values
   always_comb begin
      stk_cnt_in = stk_cnt_ff;
      if (cmd.proc) begin
         stk_cnt_in = top_pos;
      end else if (push_en && stk_cnt_ff < jsu_pkg::STK_CNT_W'(jsu_pkg::STK_DEPTH)) begin
         stk_cnt_in = stk_cnt_ff + jsu_pkg::STK_CNT_W'(1);
      end

      phase_in    = phase_ff;
      pcnt_in     = pcnt_ff;
      hi_bits_in  = hi_bits_ff;
      step_end_in = step_end_ff;
      if (cmd.take_in) begin
         step_end_in = req_payload.string_end;
      end
      if (cmd.proc) begin
         phase_in = dec_phase;
         pcnt_in  = dec_pcnt;
         if (dec_hi_wr) begin
            hi_bits_in = hex_v[9:0];
         end
      end
      // the end of a string always leaves plain text
      if (cmd.end_step && step_end_ff) begin
         phase_in = jsu_pkg::PH_TEXT;
         pcnt_in  = '0;
      end

      enc_in      = enc_ff;
      enc_left_in = enc_left_ff;
      if (cmd.proc) begin
         enc_in[0]   = dec_byte[1];
         enc_in[1]   = dec_byte[2];
         enc_in[2]   = dec_byte[3];
         enc_left_in = (dec_len > 3'd1) ? 2'(dec_len - 3'd1) : 2'd0;
      end else if (cmd.emit) begin
         enc_in[0]   = enc_ff[1];
         enc_in[1]   = enc_ff[2];
         enc_left_in = enc_left_ff - 2'd1;
      end

      rep_left_in = rep_left_ff;
      rep_end_in  = rep_end_ff;
      if (cmd.proc) begin
         rep_left_in = dec_rep_n;
         rep_end_in  = dec_rep_e;
      end else if (cmd.replay) begin
         rep_left_in = rep_pos;
         rep_end_in  = 1'b0;
      end

      emit_cnt_in = emit_cnt_ff;
      if (cmd.take_in) begin
         emit_cnt_in = '0;
      end else if (em_do) begin
         emit_cnt_in = emit_cnt_ff + jsu_pkg::OUT_CNT_W'(1);
      end

      hold_vld_in  = hold_vld_ff;
      hold_byte_in = hold_byte_ff;
      hold_last_in = hold_last_ff;
      if (em_do) begin
         hold_vld_in  = 1'b1;
         hold_byte_in = em_byte;
         hold_last_in = cmd.end_step;
      end else if (hold_move) begin
         hold_vld_in = 1'b0;
      end else if (cmd.end_step && hold_vld_ff) begin
         hold_last_in = 1'b1;
      end

      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (hold_move) begin
         rsp_vld_in           = 1'b1;
         rsp_data_in.out_byte = hold_byte_ff;
         rsp_data_in.run_last = hold_last_ff;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stk_cnt_ff   <= '0;
         phase_ff     <= jsu_pkg::PH_TEXT;
         pcnt_ff      <= '0;
         step_end_ff  <= 1'b0;
         enc_left_ff  <= '0;
         rep_left_ff  <= '0;
         rep_end_ff   <= 1'b0;
         emit_cnt_ff  <= '0;
         hold_vld_ff  <= 1'b0;
         hold_last_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         stk_cnt_ff   <= stk_cnt_in;
         phase_ff     <= phase_in;
         pcnt_ff      <= pcnt_in;
         step_end_ff  <= step_end_in;
         enc_left_ff  <= enc_left_in;
         rep_left_ff  <= rep_left_in;
         rep_end_ff   <= rep_end_in;
         emit_cnt_ff  <= emit_cnt_in;
         hold_vld_ff  <= hold_vld_in;
         hold_last_ff <= hold_last_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hi_bits_ff   <= hi_bits_in;
      enc_ff       <= enc_in;
      hold_byte_ff <= hold_byte_in;
      rsp_data_ff  <= rsp_data_in;
      if (push_en && stk_cnt_ff < jsu_pkg::STK_CNT_W'(jsu_pkg::STK_DEPTH)) begin
         stk_byte_ff[stk_cnt_ff[jsu_pkg::STK_IDX_W-1:0]] <= push_byte;
         stk_end_ff[stk_cnt_ff[jsu_pkg::STK_IDX_W-1:0]]  <= push_end;
      end
      if (cmd.proc && dec_wr_pend) begin
         pend_ff[pcnt_ff] <= cur_byte;
      end
   end

   // Status to the controller
   always_comb begin
      status.proc_block = (dec_len != 3'd0) && cap_ok && !emit_ok;
      status.emit_block = cap_ok && !emit_ok;
      status.dec_more   = dec_len > 3'd1;
      status.dec_rep    = dec_rep_n != '0;
      status.stk_more   = stk_cnt_ff > jsu_pkg::STK_CNT_W'(1);
      status.stk_any    = stk_cnt_ff != '0;
      status.enc_more   = enc_left_ff > 2'd1;
      status.rep_more   = rep_left_ff > jsu_pkg::PEND_IDX_W'(1);
      status.rep_any    = rep_left_ff != '0;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

@@ rtl/jsu_checker.sv @@
module jsu_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input jsu_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input jsu_pkg::rsp_payload_type rsp_payload
);

   // Reset empties the output stage
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its beat
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // One beat at a time: the decoder is busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an accept");

endmodule

bind json_string_unescape_to_utf8_top jsu_checker u_jsu_checker (.*);
